// File: rtl/fractal_gradient_noise_macros.svh
`ifndef FRACTAL_GRADIENT_NOISE_MACROS_SVH
`define FRACTAL_GRADIENT_NOISE_MACROS_SVH

// same-cycle implication on the block clock
`define FGN_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock
`define FGN_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fgn_pkg.sv
package fgn_pkg;

   localparam int TABLE_SIZE      = 256;
   localparam int TAB_W           = 8;
   localparam int MAX_OCTAVES_DEF = 8;
   localparam int COORD_FRAC_DEF  = 16;
   localparam int ONE_Q16         = 65536;
   localparam int MUL_A_W         = 20;
   localparam int MUL_B_W         = 37;
   localparam int PROD_W          = MUL_A_W + MUL_B_W;
   localparam int QUO_W           = 17;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 17;

   typedef enum logic [1:0] {
      MODE_PLAIN2D = 2'd0,
      MODE_PLAIN3D = 2'd1,
      MODE_RIDGED  = 2'd2,
      MODE_BILLOW  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE    = 2'd0,
      CSR_OCTAVES = 2'd1,
      CSR_PERSIST = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_READ,
      ST_FADE1,
      ST_FADE2,
      ST_FADE3,
      ST_FADE4,
      ST_GRAD,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_SHAPE,
      ST_RIDGE1,
      ST_RIDGE2,
      ST_RIDGE3,
      ST_ACC_MUL,
      ST_ACC,
      ST_AMP,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef logic signed [19:0] val_type;
   typedef logic signed [17:0] frac_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic val_type grad2(input logic [7:0] h, input frac_type x,
                                     input frac_type y);
      val_type u;
      val_type v;
      u = h[1] ? val_type'(y) : val_type'(x);
      v = h[1] ? val_type'(x) : val_type'(y);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic val_type grad3(input logic [7:0] h, input frac_type x,
                                     input frac_type y, input frac_type z);
      logic [3:0] hh;
      val_type u;
      val_type v;
      hh = h[3:0];
      u = (hh < 4'd8) ? val_type'(x) : val_type'(y);
      if (hh < 4'd4) begin
         v = val_type'(y);
      end else if (hh == 4'd12 || hh == 4'd14) begin
         v = val_type'(x);
      end else begin
         v = val_type'(z);
      end
      return (hh[0] ? -u : u) + (hh[1] ? -v : v);
   endfunction

endpackage

// File: rtl/fgn_mul.sv
module fgn_mul
   import fgn_pkg::*;
(
   input  logic                       clock,
   input  logic signed [MUL_A_W-1:0]  mul_a,
   input  logic signed [MUL_B_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]   prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign prod = prod_ff;

endmodule

// File: rtl/fgn_div.sv
module fgn_div
   import fgn_pkg::*;
#(
   parameter int NUM_W = 37,
   parameter int DEN_W = 21
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   dividend,
   input  logic [DEN_W-1:0]   divisor,
   output logic [QUO_W-1:0]   quotient,
   output div_stat_type       stat
);

   localparam int WORK_W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;
   localparam int CNT_W  = $clog2(QUO_W + 1);

   logic [WORK_W-1:0] rem_ff;
   logic [WORK_W-1:0] den_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // restoring division, quotient known to stay below 2^17
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= WORK_W'(dividend);
         den_ff <= WORK_W'(divisor) << (QUO_W - 1);
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (rem_ff >= den_ff) begin
            rem_ff <= rem_ff - den_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         den_ff <= den_ff >> 1;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/fractal_gradient_noise.sv
// channel  | dir | ports                          | content
// req      | in  | req_tvalid/tready/tdata/tuser  | load entry or evaluate point
// rsp      | out | rsp_tvalid/tready/tdata        | normalized noise value
// csr      | in  | csr_we/csr_addr/csr_wdata      | mode, octave count, persistence
//
// a load is written straight into the permutation memory
// an evaluation works through its octaves one after another, then divides;
// each octave is bound by one memory read port and one shared multiplier
// synchronous reset clears control state, the permutation memory is not cleared
// a finished result waits in the output register while the next item is taken
`include "fractal_gradient_noise_macros.svh"

module fractal_gradient_noise
   import fgn_pkg::*;
#(
   parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // table_index, table_value, coord_x, coord_y, coord_z
   input  logic [111:0]           req_tdata,
   // command
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // noise_value
   output logic [15:0]            rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
   localparam int ACC_W   = 33 + $clog2(MAX_OCTAVES + 1);
   localparam int SAMP_W  = 17 + $clog2(MAX_OCTAVES + 1);
   localparam int SPLIT_W = COORD_FRAC_BITS + 8;

   state_type state_ff, state_in;

   mode_type    mode_ff;
   logic [3:0]  octaves_ff;
   logic [16:0] persist_ff;

   logic [31:0] cx_ff, cy_ff, cz_ff;
   logic [OCT_W-1:0] n_ff, oct_ff;
   logic [16:0] pers_ff, amp_ff, weight_ff, s_ff;
   logic [ACC_W-1:0]  total_ff;
   logic [SAMP_W-1:0] sum_amp_ff;

   logic [7:0]  cell_x_ff, cell_y_ff, cell_z_ff;
   logic [15:0] fx_ff, fy_ff, fz_ff;

   logic [TAB_W-1:0] perm_mem [TABLE_SIZE];
   logic [TAB_W-1:0] rdata_ff;
   logic [TAB_W-1:0] rd_addr;
   logic [3:0]  rd_cnt_ff;
   logic [7:0]  r0_ff [2];
   logic [7:0]  r1_ff [4];
   logic [7:0]  r2_ff [8];

   logic [1:0]  fi_ff;
   logic [31:0] t2_ff;
   logic [16:0] fade_u_ff, fade_v_ff, fade_w_ff;

   val_type     g_ff [8];
   val_type     lv_ff [7];
   logic [2:0]  lc_ff;

   logic        rsp_tvalid_ff;
   logic [15:0] rsp_tdata_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic [QUO_W-1:0] quotient;
   div_stat_type     div_stat;
   logic             div_start;

   logic is3d, ridged, folded;
   logic load_item, eval_item, rsp_load;
   logic [3:0] n_reads;
   logic [1:0] fade_last;
   logic [2:0] lerp_last;

   assign is3d      = (mode_ff == MODE_PLAIN3D);
   assign ridged    = (mode_ff == MODE_RIDGED);
   assign folded    = (mode_ff == MODE_RIDGED) || (mode_ff == MODE_BILLOW);
   assign n_reads   = is3d ? 4'd14 : 4'd6;
   assign fade_last = is3d ? 2'd2 : 2'd1;
   assign lerp_last = is3d ? 3'd6 : 3'd2;

   assign load_item = (state_ff == ST_IDLE) && req_tvalid && (req_tuser == CMD_LOAD);
   assign eval_item = (state_ff == ST_IDLE) && req_tvalid && (req_tuser == CMD_EVAL);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // cell and fraction of each axis at the current octave
   logic [SPLIT_W-1:0] sx, sy, sz;
   logic [15:0] fxn, fyn, fzn;
   assign sx = cx_ff[SPLIT_W-1:0] << oct_ff;
   assign sy = cy_ff[SPLIT_W-1:0] << oct_ff;
   assign sz = cz_ff[SPLIT_W-1:0] << oct_ff;
   generate
      if (COORD_FRAC_BITS >= 16) begin : g_frac_trunc
         assign fxn = sx[COORD_FRAC_BITS-1 -: 16];
         assign fyn = sy[COORD_FRAC_BITS-1 -: 16];
         assign fzn = sz[COORD_FRAC_BITS-1 -: 16];
      end else begin : g_frac_pad
         assign fxn = {sx[COORD_FRAC_BITS-1:0], {(16 - COORD_FRAC_BITS){1'b0}}};
         assign fyn = {sy[COORD_FRAC_BITS-1:0], {(16 - COORD_FRAC_BITS){1'b0}}};
         assign fzn = {sz[COORD_FRAC_BITS-1:0], {(16 - COORD_FRAC_BITS){1'b0}}};
      end
   endgenerate

   // fade operands
   logic [15:0] t_sel;
   logic [37:0] q_full;
   always_comb begin
      case (fi_ff)
         2'd0:    t_sel = fx_ff;
         2'd1:    t_sel = fy_ff;
         default: t_sel = fz_ff;
      endcase
      q_full = ({6'd0, t2_ff} * 38'd6) + (38'd10 << 32) - (({22'd0, t_sel} * 38'd15) << 16);
   end

   // lerp operands
   val_type     la, lb;
   logic [16:0] lt;
   always_comb begin
      case (lc_ff)
         3'd0:    begin la = g_ff[0];  lb = g_ff[1];  lt = fade_u_ff; end
         3'd1:    begin la = g_ff[2];  lb = g_ff[3];  lt = fade_u_ff; end
         3'd2:    begin la = lv_ff[0]; lb = lv_ff[1]; lt = fade_v_ff; end
         3'd3:    begin la = g_ff[4];  lb = g_ff[5];  lt = fade_u_ff; end
         3'd4:    begin la = g_ff[6];  lb = g_ff[7];  lt = fade_u_ff; end
         3'd5:    begin la = lv_ff[3]; lb = lv_ff[4]; lt = fade_v_ff; end
         default: begin la = lv_ff[2]; lb = lv_ff[5]; lt = fade_w_ff; end
      endcase
   end

   // remap and folding of one octave sample
   val_type     res, half;
   logic [16:0] plain, fold, shaped;
   always_comb begin
      res  = is3d ? lv_ff[6] : lv_ff[2];
      half = (res + val_type'(ONE_Q16)) >>> 1;
      if (half < 0) begin
         plain = '0;
      end else if (half > val_type'(ONE_Q16)) begin
         plain = 17'h10000;
      end else begin
         plain = half[16:0];
      end
      fold   = (plain >= 17'd32768) ? plain - 17'd32768 : 17'd32768 - plain;
      shaped = folded ? (fold << 1) : plain;
   end

   // gradients
   frac_type x0, x1, y0, y1, z0, z1;
   assign x0 = signed'({2'b00, fx_ff});
   assign y0 = signed'({2'b00, fy_ff});
   assign z0 = signed'({2'b00, fz_ff});
   assign x1 = x0 - 18'sd65536;
   assign y1 = y0 - 18'sd65536;
   assign z1 = z0 - 18'sd65536;

   // read address of the hash chain
   logic [3:0] rd_j, rd_k, slot, slot_j, slot_k;
   always_comb begin
      rd_j = rd_cnt_ff - 4'd2;
      rd_k = rd_cnt_ff - 4'd6;
      if (rd_cnt_ff < 4'd2) begin
         rd_addr = cell_x_ff + {7'd0, rd_cnt_ff[0]};
      end else if (rd_cnt_ff < 4'd6) begin
         rd_addr = r0_ff[rd_j[1]] + cell_y_ff + {7'd0, rd_j[0]};
      end else begin
         rd_addr = r1_ff[rd_k[2:1]] + cell_z_ff + {7'd0, rd_k[0]};
      end
      slot   = rd_cnt_ff - 4'd1;
      slot_j = slot - 4'd2;
      slot_k = slot - 4'd6;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (eval_item) state_in = ST_SPLIT;
         ST_SPLIT:     state_in = ST_READ;
         ST_READ:      if (rd_cnt_ff == n_reads) state_in = ST_FADE1;
         ST_FADE1:     state_in = ST_FADE2;
         ST_FADE2:     state_in = ST_FADE3;
         ST_FADE3:     state_in = ST_FADE4;
         ST_FADE4:     state_in = (fi_ff == fade_last) ? ST_GRAD : ST_FADE1;
         ST_GRAD:      state_in = ST_LERP_MUL;
         ST_LERP_MUL:  state_in = ST_LERP_ADD;
         ST_LERP_ADD:  state_in = (lc_ff == lerp_last) ? ST_SHAPE : ST_LERP_MUL;
         ST_SHAPE:     state_in = ridged ? ST_RIDGE1 : ST_ACC_MUL;
         ST_RIDGE1:    state_in = ST_RIDGE2;
         ST_RIDGE2:    state_in = ST_RIDGE3;
         ST_RIDGE3:    state_in = ST_ACC_MUL;
         ST_ACC_MUL:   state_in = ST_ACC;
         ST_ACC:       state_in = ST_AMP;
         ST_AMP:       state_in = (oct_ff + 1'b1 == n_ff) ? ST_DIV_START : ST_SPLIT;
         ST_DIV_START: state_in = ST_DIV;
         ST_DIV:       if (div_stat.done) state_in = ST_DONE;
         ST_DONE:      if (rsp_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_FADE1:     begin mul_a = MUL_A_W'(t_sel); mul_b = MUL_B_W'(t_sel); end
         ST_FADE2:     begin mul_a = MUL_A_W'(prod[31:16]); mul_b = MUL_B_W'(t_sel); end
         ST_FADE3:     begin
            mul_a = MUL_A_W'(prod[31:16]);
            mul_b = {1'b0, q_full[35:0]};
         end
         ST_LERP_MUL:  begin mul_a = MUL_A_W'(lb - la); mul_b = MUL_B_W'(lt); end
         ST_RIDGE1:    begin
            mul_a = MUL_A_W'(17'h10000 - s_ff);
            mul_b = MUL_B_W'(17'h10000 - s_ff);
         end
         ST_RIDGE2:    begin mul_a = MUL_A_W'(prod[32:16]); mul_b = MUL_B_W'(weight_ff); end
         ST_ACC_MUL:   begin mul_a = MUL_A_W'(s_ff); mul_b = MUL_B_W'(amp_ff); end
         ST_ACC:       begin mul_a = MUL_A_W'(amp_ff); mul_b = MUL_B_W'(pers_ff); end
         ST_DIV_START: div_start = 1'b1;
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PLAIN2D;
         octaves_ff <= 4'd1;
         persist_ff <= 17'd32768;
      end else if (csr_we) begin
         if (csr_addr == CSR_MODE) mode_ff <= mode_type'(csr_wdata[1:0]);
         if (csr_addr == CSR_OCTAVES) octaves_ff <= csr_wdata[3:0];
         if (csr_addr == CSR_PERSIST) persist_ff <= csr_wdata;
      end
   end

   // permutation memory
   always_ff @(posedge clock) begin
      if (load_item) perm_mem[req_tdata[7:0]] <= req_tdata[15:8];
      rdata_ff <= perm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= (quotient > 17'd65535) ? 16'hffff : quotient[15:0];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (eval_item) begin
               cx_ff <= req_tdata[47:16];
               cy_ff <= req_tdata[79:48];
               cz_ff <= req_tdata[111:80];
               if (octaves_ff == 4'd0) begin
                  n_ff <= OCT_W'(1);
               end else if ({1'b0, octaves_ff} > 5'(MAX_OCTAVES)) begin
                  n_ff <= OCT_W'(MAX_OCTAVES);
               end else begin
                  n_ff <= OCT_W'(octaves_ff);
               end
               pers_ff    <= (persist_ff > 17'h10000) ? 17'h10000 : persist_ff;
               oct_ff     <= '0;
               amp_ff     <= 17'h10000;
               weight_ff  <= 17'h10000;
               total_ff   <= '0;
               sum_amp_ff <= '0;
            end
         end
         ST_SPLIT: begin
            cell_x_ff <= sx[SPLIT_W-1:COORD_FRAC_BITS];
            cell_y_ff <= sy[SPLIT_W-1:COORD_FRAC_BITS];
            cell_z_ff <= sz[SPLIT_W-1:COORD_FRAC_BITS];
            fx_ff     <= fxn;
            fy_ff     <= fyn;
            fz_ff     <= fzn;
            rd_cnt_ff <= '0;
         end
         ST_READ: begin
            rd_cnt_ff <= rd_cnt_ff + 4'd1;
            fi_ff     <= '0;
            if (rd_cnt_ff != 4'd0) begin
               if (slot < 4'd2) begin
                  r0_ff[slot[0]] <= rdata_ff;
               end else if (slot < 4'd6) begin
                  r1_ff[slot_j[1:0]] <= rdata_ff;
               end else begin
                  r2_ff[slot_k[2:0]] <= rdata_ff;
               end
            end
         end
         ST_FADE2: t2_ff <= prod[31:0];
         ST_FADE4: begin
            case (fi_ff)
               2'd0:    fade_u_ff <= prod[48:32];
               2'd1:    fade_v_ff <= prod[48:32];
               default: fade_w_ff <= prod[48:32];
            endcase
            fi_ff <= fi_ff + 2'd1;
         end
         ST_GRAD: begin
            if (is3d) begin
               g_ff[0] <= grad3(r2_ff[0], x0, y0, z0);
               g_ff[1] <= grad3(r2_ff[4], x1, y0, z0);
               g_ff[2] <= grad3(r2_ff[2], x0, y1, z0);
               g_ff[3] <= grad3(r2_ff[6], x1, y1, z0);
               g_ff[4] <= grad3(r2_ff[1], x0, y0, z1);
               g_ff[5] <= grad3(r2_ff[5], x1, y0, z1);
               g_ff[6] <= grad3(r2_ff[3], x0, y1, z1);
               g_ff[7] <= grad3(r2_ff[7], x1, y1, z1);
            end else begin
               g_ff[0] <= grad2(r1_ff[0], x0, y0);
               g_ff[1] <= grad2(r1_ff[2], x1, y0);
               g_ff[2] <= grad2(r1_ff[1], x0, y1);
               g_ff[3] <= grad2(r1_ff[3], x1, y1);
            end
            lc_ff <= '0;
         end
         ST_LERP_ADD: begin
            lv_ff[lc_ff] <= la + val_type'(prod >>> 16);
            lc_ff        <= lc_ff + 3'd1;
         end
         ST_SHAPE: s_ff <= shaped;
         ST_RIDGE3: begin
            s_ff      <= prod[32:16];
            weight_ff <= (prod[32:16] >= 17'd32768) ? 17'h10000 : {prod[31:16], 1'b0};
         end
         ST_ACC: begin
            total_ff   <= total_ff + ACC_W'(prod[32:0]);
            sum_amp_ff <= sum_amp_ff + SAMP_W'(amp_ff);
         end
         ST_AMP: begin
            amp_ff <= prod[32:16];
            oct_ff <= oct_ff + 1'b1;
         end
         default: ;
      endcase
   end

   fgn_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   fgn_div #(
      .NUM_W (ACC_W),
      .DEN_W (SAMP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (sum_amp_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `FGN_ASSERT_IMP(a_div_in_step, div_stat.busy || div_stat.done, state_ff == ST_DIV, "divider active outside the divide step")
   `FGN_ASSERT_IMP(a_oct_bound, state_ff != ST_IDLE, oct_ff <= n_ff, "octave counter past octave count")
   `FGN_ASSERT_NXT(a_eval_start, eval_item, state_ff == ST_SPLIT, "evaluate transfer did not start an octave")
   `FGN_ASSERT_IMP(a_read_bound, state_ff == ST_READ, rd_cnt_ff <= 4'd14, "hash read counter overran")

endmodule

// File: sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fgn_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 32;

   class noise_scoreboard;
      logic [7:0]  perm_table [TABLE_SIZE];
      mode_type    mode;
      logic [3:0]  octaves;
      logic [16:0] persist;
      int          noise_queue[$];
      int          errors;
      int          evals;
      int          loads;

      function new();
         mode    = MODE_PLAIN2D;
         octaves = 4'd1;
         persist = 17'd32768;
         errors  = 0;
         evals   = 0;
         loads   = 0;
         foreach (perm_table[i]) perm_table[i] = 8'd0;
      endfunction

      function void set_reg(csr_index_type idx, logic [16:0] value);
         case (idx)
            CSR_MODE:    mode    = mode_type'(value[1:0]);
            CSR_OCTAVES: octaves = value[3:0];
            CSR_PERSIST: persist = value;
            default: ;
         endcase
      endfunction

      function longint perm(longint unsigned i);
         return longint'(perm_table[i & 255]);
      endfunction

      function void split_axis(longint unsigned c, int oct, output longint unsigned grid,
                               output longint frac);
         longint unsigned s;
         s = c << oct;
         grid = (s >> 16) & 255;
         frac = longint'(s & 64'hffff);
      endfunction

      function longint fade(longint t);
         longint unsigned a, q, c;
         a = t;
         q = 6 * a * a + (64'd10 << 32) - 15 * (a << 16);
         c = (a * a) >> 16;
         c = (c * a) >> 16;
         return longint'((c * q) >> 32);
      endfunction

      function longint lerp(longint t, longint a, longint b);
         return a + (((b - a) * t) >>> 16);
      endfunction

      function longint grad2(longint h, longint x, longint y);
         longint u, v;
         h = h & 3;
         u = (h < 2) ? x : y;
         v = (h < 2) ? y : x;
         return (h[0] ? -u : u) + (h[1] ? -v : v);
      endfunction

      function longint grad3(longint h, longint x, longint y, longint z);
         longint u, v;
         h = h & 15;
         u = (h < 8) ? x : y;
         v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
         return (h[0] ? -u : u) + (h[1] ? -v : v);
      endfunction

      function longint remap(longint res);
         longint s;
         s = (res + ONE_Q16) >>> 1;
         if (s < 0) s = 0;
         if (s > ONE_Q16) s = ONE_Q16;
         return s;
      endfunction

      function longint octave2(longint unsigned cx, longint unsigned cy, int oct);
         longint unsigned gx, gy, gx1, aa, ab, ba, bb;
         longint fx, fy, u, v;
         split_axis(cx, oct, gx, fx);
         split_axis(cy, oct, gy, fy);
         u = fade(fx);
         v = fade(fy);
         gx1 = (gx + 1) & 255;
         aa = perm(perm(gx) + gy);
         ab = perm(perm(gx) + gy + 1);
         ba = perm(perm(gx1) + gy);
         bb = perm(perm(gx1) + gy + 1);
         return remap(lerp(v,
            lerp(u, grad2(aa, fx, fy), grad2(ba, fx - ONE_Q16, fy)),
            lerp(u, grad2(ab, fx, fy - ONE_Q16), grad2(bb, fx - ONE_Q16, fy - ONE_Q16))));
      endfunction

      function longint octave3(longint unsigned cx, longint unsigned cy, longint unsigned cz,
                               int oct);
         longint unsigned gx, gy, gz, a, b, aa, ab, ba, bb;
         longint fx, fy, fz, u, v, w, x1, y1, z1, lo, hi;
         split_axis(cx, oct, gx, fx);
         split_axis(cy, oct, gy, fy);
         split_axis(cz, oct, gz, fz);
         u = fade(fx);
         v = fade(fy);
         w = fade(fz);
         x1 = fx - ONE_Q16;
         y1 = fy - ONE_Q16;
         z1 = fz - ONE_Q16;
         a  = perm(gx) + gy;
         aa = perm(a) + gz;
         ab = perm(a + 1) + gz;
         b  = perm((gx + 1) & 255) + gy;
         ba = perm(b) + gz;
         bb = perm(b + 1) + gz;
         lo = lerp(v, lerp(u, grad3(perm(aa), fx, fy, fz), grad3(perm(ba), x1, fy, fz)),
                      lerp(u, grad3(perm(ab), fx, y1, fz), grad3(perm(bb), x1, y1, fz)));
         hi = lerp(v, lerp(u, grad3(perm(aa + 1), fx, fy, z1), grad3(perm(ba + 1), x1, fy, z1)),
                      lerp(u, grad3(perm(ab + 1), fx, y1, z1),
                           grad3(perm(bb + 1), x1, y1, z1)));
         return remap(lerp(w, lo, hi));
      endfunction

      function int fractal_noise(logic [31:0] x, logic [31:0] y, logic [31:0] z);
         longint unsigned cx, cy, cz, amp, pers, total, sum_amp, q;
         longint weight, s, r;
         int n;
         cx = longint'($signed(x));
         cy = longint'($signed(y));
         cz = longint'($signed(z));
         n = (octaves < 1) ? 1 : ((octaves > 8) ? 8 : int'(octaves));
         pers = (persist > ONE_Q16) ? ONE_Q16 : persist;
         amp = ONE_Q16;
         total = 0;
         sum_amp = 0;
         weight = ONE_Q16;
         for (int i = 0; i < n; i++) begin
            if (mode == MODE_PLAIN3D) begin
               s = octave3(cx, cy, cz, i);
            end else begin
               s = octave2(cx, cy, i);
               if (mode == MODE_RIDGED || mode == MODE_BILLOW) begin
                  s = 2 * ((s >= 32768) ? s - 32768 : 32768 - s);
                  if (mode == MODE_RIDGED) begin
                     r = ONE_Q16 - s;
                     s = (r * r) >>> 16;
                     s = (s * weight) >>> 16;
                     weight = 2 * s;
                     if (weight > ONE_Q16) weight = ONE_Q16;
                  end
               end
            end
            total += longint'(s) * amp;
            sum_amp += amp;
            amp = (amp * pers) >> 16;
         end
         q = total / sum_amp;
         return (q > 65535) ? 65535 : int'(q);
      endfunction

      function void note_request(cmd_type cmd, logic [111:0] data);
         if (cmd == CMD_LOAD) begin
            perm_table[data[7:0]] = data[15:8];
            loads++;
         end else begin
            noise_queue.push_back(fractal_noise(data[47:16], data[79:48], data[111:80]));
            evals++;
         end
      endfunction

      function void check_result(logic [15:0] actual);
         int want;
         if (noise_queue.size() == 0) begin
            $error("unexpected noise_value transfer: %0d", actual);
            errors++;
         end else begin
            want = noise_queue.pop_front();
            if (int'(actual) != want) begin
               $error("noise_value mismatch: expected %0d actual %0d", want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [111:0]   req_tdata = '0;
   logic           req_tuser = 1'b0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [15:0]    rsp_tdata;
   logic           csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   noise_scoreboard sb = new();
   bit no_idle = 1'b0;
   int quiet_cycles = 0;

   fractal_gradient_noise dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(cmd_type cmd, logic [111:0] data);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, data);
   endtask

   task automatic send_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      send_item(CMD_EVAL, {z, y, x, 16'd0});
   endtask

   task automatic send_load(logic [7:0] idx, logic [7:0] value);
      send_item(CMD_LOAD, {96'd0, value, idx});
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.noise_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // block must be idle on entry
   task automatic configure(mode_type m, logic [3:0] oct, logic [16:0] pers);
      csr_we <= 1'b1;
      csr_addr <= CSR_MODE;
      csr_wdata <= 17'(m);
      @(posedge clock);
      sb.set_reg(CSR_MODE, 17'(m));
      csr_addr <= CSR_OCTAVES;
      csr_wdata <= 17'(oct);
      @(posedge clock);
      sb.set_reg(CSR_OCTAVES, 17'(oct));
      csr_addr <= CSR_PERSIST;
      csr_wdata <= pers;
      @(posedge clock);
      sb.set_reg(CSR_PERSIST, pers);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2047)) - 1024) << 10;
         default: return {{16{1'($urandom_range(1))}}, 16'($urandom_range(65535))} ^
                         (32'($urandom_range(255)) << 16);
      endcase
   endfunction

   initial begin
      logic [7:0] shuffle [256];
      logic [31:0] corner [8];
      logic [7:0] tmp;
      int j;
      mode_type m;
      corner = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                 32'h0000ffff, 32'h00010000, 32'hffff0001, 32'h00ff8000};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole permutation table before any evaluation
      foreach (shuffle[i]) shuffle[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = shuffle[i];
         shuffle[i] = shuffle[j];
         shuffle[j] = tmp;
      end
      for (int i = 0; i < 256; i++) send_load(8'(i), shuffle[i]);
      send_load(8'hff, 8'hff);
      send_load(8'h00, 8'h00);
      wait_idle();

      // directed: corner coordinates in every mode, octave and persistence extremes
      configure(MODE_PLAIN2D, 4'd1, 17'd0);
      for (int i = 0; i < 4; i++) send_eval(corner[i], corner[7 - i], corner[i]);
      wait_idle();
      configure(MODE_PLAIN3D, 4'd8, 17'd65536);
      for (int i = 0; i < 4; i++) send_eval(corner[i + 4], corner[i], corner[7 - i]);
      wait_idle();
      configure(MODE_RIDGED, 4'd0, 17'h1ffff);
      send_eval(corner[1], corner[2], 32'h0);
      send_eval(corner[4], corner[5], 32'h0);
      wait_idle();
      configure(MODE_RIDGED, 4'd15, 17'd65535);
      send_eval(corner[6], corner[7], 32'h0);
      send_eval(corner[3], corner[0], 32'h0);
      wait_idle();
      configure(MODE_BILLOW, 4'd8, 17'd32768);
      send_eval(corner[2], corner[1], 32'h0);
      send_eval(corner[5], corner[6], 32'h0);
      wait_idle();

      // random phases, each under its own register setting
      for (int p = 0; p < 8; p++) begin
         m = mode_type'(p % 4);
         no_idle = (p == 5);
         if (p == 0) configure(m, 4'd8, 17'd65536);
         else if (p == 7) configure(m, 4'd1, 17'd0);
         else configure(m, 4'($urandom_range(15)), 17'($urandom_range(131071)));
         for (int k = 0; k < 18; k++) begin
            if ($urandom_range(99) < 12) begin
               send_load(8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
               send_eval(random_coord(), random_coord(), random_coord());
            end
            if (p == 2 && k == 9) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (sb.noise_queue.size() != 0) @(posedge clock);
            end
         end
         wait_idle();
      end
      no_idle = 1'b0;

      $display("covered %0d evaluations and %0d table loads", sb.evals, sb.loads);
      $display("all four modes, octave counts 0..15, persistence 0 to above one");
      if (sb.errors == 0 && sb.noise_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
